### rtl/core/ptds_pkg.sv
// ptds_pkg: types and codes shared by the deadline scheduler cells and top level
// no dependencies
package ptds_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_REG   = 2'd1;
    localparam logic [1:0] OP_DEREG = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [15:0] MIN_PERIOD_RESET = 16'd10;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now;
        logic [15:0] task_key;
        logic [31:0] period;
    } t_in_word;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_key;
        logic [31:0] elapsed;
        logic [1:0]  status;
        logic [5:0]  active_count;
    } t_out_word;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [31:0] origin;
    } t_entry;

    // command from the sequencer to every cell
    typedef struct packed {
        logic        shift;   // shift chain towards cell 0 by one place
        logic        upd;     // rewrite this cell's entry with upd_val (shift wins if both are set)
        t_entry      upd_val;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } t_state;

endpackage

### rtl/core/ptds_cell.sv
// ptds_cell: one table slot in the chain, takes its neighbour's entry on shift
// depends on ptds_pkg
module ptds_cell
    import ptds_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_next,
    output t_entry    o_entry
);
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.upd) begin
            r_entry <= i_ctl.upd_val;
        end
    end

    assign o_entry = r_entry;
endmodule

### rtl/core/periodic_task_deadline_scheduler_top.sv
// periodic_task_deadline_scheduler_top: deadline table as a rotating ring of cells
// depends on ptds_pkg and ptds_cell
// per input word: a scan state that turns the ring once round, then an apply state,
// then a done state that holds the result word until it is taken (i_stall low)
// a new word is taken only in idle, so a stalled result also holds off the next word
// reset: synchronous active low, clears count, sequencer and min_period to 10
// table contents are not reset
module periodic_task_deadline_scheduler_top
    import ptds_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] LASTP = CW'(MAX_ENTRIES - 1);

    t_state        r_state, n_state;
    logic [15:0]   r_minp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pos;       // logical index of entry at head during scan
    t_in_word      r_in;
    logic          r_found;
    logic [CW-1:0] r_fidx;      // logical index of key match
    t_entry        r_match;
    logic          r_bvalid;
    logic [CW-1:0] r_bidx;
    t_entry        r_best;
    t_out_word     r_out;

    t_entry        w_ent [MAX_ENTRIES];
    t_entry        w_head;
    logic          w_in_tab, w_better, w_hit;
    logic          w_wr, w_drop;
    logic [CW-1:0] w_widx;
    t_entry        w_new;
    t_out_word     w_res;

    assign w_head = w_ent[0];

    // ring: cell i takes from i+1, last takes head; back home after a full scan
    // on drop, cells from the removed slot on take their neighbour
    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            localparam logic [CW-1:0] CI = CW'(g);
            t_cell_ctl w_cctl;
            always_comb begin
                w_cctl.shift   = (r_state == S_SCAN) || (w_drop && CI >= r_fidx);
                w_cctl.upd     = w_wr && (CI == w_widx);
                w_cctl.upd_val = w_new;
            end
            ptds_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_cctl),
                .i_next (w_ent[(g + 1) % MAX_ENTRIES]),
                .o_entry(w_ent[g])
            );
        end
    endgenerate

    assign w_in_tab = r_pos < r_cnt;
    assign w_better = !r_bvalid || (w_head.deadline < r_best.deadline);
    assign w_hit    = w_in_tab && !r_found && (w_head.key == r_in.task_key);

    assign pready  = 1'b1;
    assign prdata  = {16'd0, r_minp};
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minp <= MIN_PERIOD_RESET;
        end else if (psel && penable && pwrite && !paddr) begin
            r_minp <= pwdata[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_SCAN;
            S_SCAN:  if (r_pos == LASTP) n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_valid = (r_state == S_DONE);
    end

    // result and table edit, used in the apply cycle with the ring at home
    always_comb begin
        w_res  = '0;
        w_new  = r_best;
        w_wr   = 1'b0;
        w_drop = 1'b0;
        w_widx = r_bidx;
        n_cnt  = r_cnt;
        case (r_in.opcode)
            OP_TICK: begin
                if (r_cnt != '0 && r_best.deadline <= r_in.now) begin
                    w_res.fired     = 1'b1;
                    w_res.fired_key = r_best.key;
                    w_res.elapsed   = r_in.now - r_best.origin;
                    w_new.deadline  = r_in.now + r_best.period;
                    w_wr            = 1'b1;
                end
            end
            OP_REG: begin
                if (r_in.period < {16'd0, r_minp}) begin
                    w_res.status = ST_SHORT;
                end else if (r_found) begin
                    w_new          = r_match;
                    w_new.period   = r_in.period;
                    w_new.deadline = r_match.deadline + (r_in.period - r_match.period);
                    w_widx         = r_fidx;
                    w_wr           = 1'b1;
                end else if (r_cnt >= MAXC) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_new.key      = r_in.task_key;
                    w_new.period   = r_in.period;
                    w_new.deadline = r_in.now + r_in.period;
                    w_new.origin   = r_in.now;
                    w_widx         = r_cnt;
                    w_wr           = 1'b1;
                    n_cnt          = r_cnt + CW'(1);
                end
            end
            OP_DEREG: begin
                if (!r_found) begin
                    w_res.status = ST_NOTFOUND;
                end else begin
                    w_drop = 1'b1;
                    n_cnt  = r_cnt - CW'(1);
                end
            end
            default: ;
        endcase
        w_res.active_count = 6'(n_cnt);
        if (r_state != S_APPLY) begin
            w_wr   = 1'b0;
            w_drop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_found  <= 1'b0;
            r_bvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in     <= i_data;
                        r_pos    <= '0;
                        r_found  <= 1'b0;
                        r_bvalid <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_pos <= r_pos + CW'(1);
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_pos;
                        r_match <= w_head;
                    end
                    if (w_in_tab && w_better) begin
                        r_bvalid <= 1'b1;
                        r_bidx   <= r_pos;
                        r_best   <= w_head;
                    end
                end
                S_APPLY: begin
                    r_cnt <= n_cnt;
                    r_out <= w_res;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAXC)
        else $error("entry count beyond table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result waits");
endmodule
